// ----- rtl/core/vopg_pkg.sv -----
package vopg_pkg;

   localparam logic [7:0] LINE_LAST     = 8'd227;
   localparam logic [7:0] VISIBLE_WIDTH = 8'd160;
   localparam logic [7:0] SYNC_START    = 8'd214;
   localparam logic [7:0] SYNC_END      = 8'd198;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] VS_BLANK = 2'd0;
   localparam logic [1:0] VS_SYNC  = 2'd1;
   localparam logic [1:0] VS_PIXEL = 2'd2;

   localparam logic [5:0] A_VSYNC  = 6'h00;
   localparam logic [5:0] A_VBLANK = 6'h01;
   localparam logic [5:0] A_WSYNC  = 6'h02;
   localparam logic [5:0] A_RSYNC  = 6'h03;
   localparam logic [5:0] A_NUSIZ0 = 6'h04;
   localparam logic [5:0] A_NUSIZ1 = 6'h05;
   localparam logic [5:0] A_COLUP0 = 6'h06;
   localparam logic [5:0] A_COLUP1 = 6'h07;
   localparam logic [5:0] A_COLUPF = 6'h08;
   localparam logic [5:0] A_COLUBK = 6'h09;
   localparam logic [5:0] A_CTRLPF = 6'h0a;
   localparam logic [5:0] A_REFP0  = 6'h0b;
   localparam logic [5:0] A_REFP1  = 6'h0c;
   localparam logic [5:0] A_PF0    = 6'h0d;
   localparam logic [5:0] A_PF1    = 6'h0e;
   localparam logic [5:0] A_PF2    = 6'h0f;
   localparam logic [5:0] A_RESP0  = 6'h10;
   localparam logic [5:0] A_RESP1  = 6'h11;
   localparam logic [5:0] A_RESM0  = 6'h12;
   localparam logic [5:0] A_RESM1  = 6'h13;
   localparam logic [5:0] A_RESBL  = 6'h14;
   localparam logic [5:0] A_GRP0   = 6'h1b;
   localparam logic [5:0] A_GRP1   = 6'h1c;
   localparam logic [5:0] A_ENAM0  = 6'h1d;
   localparam logic [5:0] A_ENAM1  = 6'h1e;
   localparam logic [5:0] A_ENABL  = 6'h1f;
   localparam logic [5:0] A_HMP0   = 6'h20;
   localparam logic [5:0] A_HMP1   = 6'h21;
   localparam logic [5:0] A_HMM0   = 6'h22;
   localparam logic [5:0] A_HMM1   = 6'h23;
   localparam logic [5:0] A_HMBL   = 6'h24;
   localparam logic [5:0] A_VDELP0 = 6'h25;
   localparam logic [5:0] A_VDELP1 = 6'h26;
   localparam logic [5:0] A_VDELBL = 6'h27;
   localparam logic [5:0] A_RESMP0 = 6'h28;
   localparam logic [5:0] A_RESMP1 = 6'h29;
   localparam logic [5:0] A_HMOVE  = 6'h2a;
   localparam logic [5:0] A_HMCLR  = 6'h2b;
   localparam logic [5:0] A_CXCLR  = 6'h2c;

   // flag word passed from the pixel stage back to the top level
   typedef struct packed {
      logic [7:0][7:0] col_or;
   } vopg_coll_type;

   // object state the pixel logic looks at
   typedef struct packed {
      logic [19:0]     pf;
      logic [4:0][7:0] pos;
      logic [3:0][7:0] colr;
      logic [2:0][7:0] ctrl;
      logic [1:0]      refl;
      logic [1:0][7:0] shape;
      logic [8:0]      edb;
   } vopg_view_type;

   function automatic logic [7:0] pos_bump(input logic [7:0] p);
      return (p >= VISIBLE_WIDTH - 8'd1) ? 8'd0 : p + 8'd1;
   endfunction

endpackage

// ----- rtl/core/vopg_pixel.sv -----
module vopg_pixel
   import vopg_pkg::*;
(
   input  vopg_view_type view,
   input  logic [7:0]    offset,
   output logic [7:0]    colour,
   output vopg_coll_type coll
);

   logic [5:0] slot;
   logic       pf, bl, pfb;
   logic [1:0] p, m;
   logic [7:0] pfc;
   logic [5:0] mir;
   logic [4:0] idx;

   function automatic logic player_px(input logic [7:0] shape, input logic [7:0] pos,
                                      input logic [2:0] sz, input logic refl);
      logic [7:0] r;
      logic       on;
      on = (shape != 8'd0) && (pos >= 8'd5);
      r  = pos - 8'd5;
      case (sz)
         3'd1: if (r >= 8'd16) r = r - 8'd16;
         3'd2: if (r >= 8'd32) r = r - 8'd32;
         3'd3: if (r >= 8'd32) r = r - 8'd32; else if (r >= 8'd16) r = r - 8'd16;
         3'd4: if (r >= 8'd64) r = r - 8'd64;
         3'd5: r = r >> 1;
         3'd6: if (r >= 8'd64) r = r - 8'd64; else if (r >= 8'd32) r = r - 8'd32;
         3'd7: r = r >> 2;
         default: r = r;
      endcase
      if (r >= 8'd8) on = 1'b0;
      return on & shape[r[2:0] ^ (refl ? 3'd0 : 3'd7)];
   endfunction

   function automatic logic span_px(input logic [7:0] pos, input logic [1:0] sz);
      logic [7:0] r;
      r = pos - 8'd4;
      return (pos >= 8'd4) && (r < (8'd1 << sz));
   endfunction

   always_comb begin
      slot = offset[7:2];
      mir  = view.ctrl[0][0] ? 6'd39 - slot : slot - 6'd20;
      idx  = (slot < 6'd20) ? slot[4:0] : mir[4:0];
      pf   = (slot < 6'd40) ? view.pf[idx] : 1'b0;
      pfc  = (view.ctrl[0][2:1] == 2'b01) ? view.colr[(slot < 6'd20) ? 1'b0 : 1'b1]
                                          : view.colr[2];
      for (int c = 0; c < 2; c++) begin
         p[c] = player_px(view.shape[c], view.pos[c], view.ctrl[1+c][2:0], view.refl[c]);
         m[c] = view.edb[c] && !view.edb[7+c] && span_px(view.pos[2+c], view.ctrl[1+c][5:4]);
      end
      bl = view.edb[2] && span_px(view.pos[4], view.ctrl[0][5:4]);

      for (int i = 0; i < 8; i++) coll.col_or[i] = 8'd0;
      if (p != 2'b00) begin
         coll.col_or[0] = {m[0] & p[1], m[0] & p[0], 6'd0};
         coll.col_or[1] = {m[1] & p[0], m[1] & p[1], 6'd0};
         coll.col_or[2] = {pf & p[0], bl & p[0], 6'd0};
         coll.col_or[3] = {pf & p[1], bl & p[1], 6'd0};
         coll.col_or[7][7] = p[0] & p[1];
      end
      if (pf | bl) begin
         coll.col_or[4] = {pf & m[0], bl & m[0], 6'd0};
         coll.col_or[5] = {pf & m[1], bl & m[1], 6'd0};
         coll.col_or[6][7] = pf & bl;
      end
      coll.col_or[7][6] = m[0] & m[1];

      pfb    = pf | bl;
      colour = pfb ? pfc : view.colr[3];
      if (!view.ctrl[0][2] || !pfb) begin
         if (p[1] | m[1]) colour = view.colr[1];
         if (p[0] | m[0]) colour = view.colr[0];
      end
   end

endmodule

// ----- rtl/core/video_object_pixel_generator_unit.sv -----
// Video object pixel generator: colour-clock core of a console video chip.
//
// Request channel (req_): one word per command. tdata holds, from bit 0 up,
// command[1:0], reg_address[7:2], write_data[15:8]. Command 0 is a colour
// clock tick, 1 a register write, 2 a collision read.
// Response channel (rsp_): exactly one word per request word, in order.
//
// All work for a word is combinational between the request handshake and
// the response register, so a new word is taken every cycle while the
// response side keeps up (one tick per clock).
// The response register acts as the only buffer: req_tready is high whenever
// the response register is empty or being emptied this cycle, so a stall on
// rsp_tready holds one word and back-pressures the request side at once.
//
// Reset (synchronous, active high) clears all but the response data; collision
// latches come up as 0xff. cpu_hold reports the sync-wait flag after each word.
module video_object_pixel_generator_unit
   import vopg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // command[1:0], reg_address[7:2], write_data[15:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // video_state[1:0], pixel_colour[9:2], pixel_valid[10],
                                   // read_data[18:11], cpu_hold[19], zero[23:20]
);

   logic [7:0]  line_ff, line_in;
   logic [19:0] pf_ff, pf_in;
   logic [7:0]  pos_ff [5];
   logic [7:0]  pos_in [5];
   logic [7:0]  cx_ff [8];
   logic [7:0]  cx_in [8];
   logic [7:0]  colr_ff [4];
   logic [7:0]  colr_in [4];
   logic [7:0]  ctrl_ff [3];
   logic [7:0]  ctrl_in [3];
   logic [1:0]  refl_ff, refl_in;
   logic [7:0]  shp_ff [2];
   logic [7:0]  shp_in [2];
   logic [7:0]  shl_ff [2];
   logic [7:0]  shl_in [2];
   logic [8:0]  edb_ff, edb_in;
   logic [3:0]  hm_ff [5];
   logic [3:0]  hm_in [5];
   logic [3:0]  mcnt_ff, mcnt_in;
   logic [4:0]  mflg_ff, mflg_in;
   logic [2:0]  mctl_ff, mctl_in;
   logic [3:0]  sbf_ff, sbf_in;

   logic        vld_ff, vld_in;
   logic [19:0] out_ff, out_in;

   logic [1:0]  cmd;
   logic [5:0]  addr;
   logic [7:0]  wd;
   logic        take;

   vopg_view_type view;
   vopg_coll_type coll;
   logic [7:0]    pix_colour;
   logic [7:0]    offset;

   logic [1:0]  st;
   logic [7:0]  colour, rd, limit;
   logic [3:0]  cv;
   logic        extend, in_vis;

   assign cmd  = req_tdata[1:0];
   assign addr = req_tdata[7:2];
   assign wd   = req_tdata[15:8];
   assign req_tready = !vld_ff || rsp_tready;
   assign take = req_tvalid && req_tready;
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {4'd0, out_ff};

   always_comb begin
      view.pf = pf_ff;
      view.refl = refl_ff;
      view.edb = edb_ff;
      for (int i = 0; i < 5; i++) view.pos[i] = pos_ff[i];
      for (int i = 0; i < 4; i++) view.colr[i] = colr_ff[i];
      for (int i = 0; i < 3; i++) view.ctrl[i] = ctrl_ff[i];
      for (int i = 0; i < 2; i++) view.shape[i] = shp_ff[i];
   end

   // positions may move during the tick before drawing: the pixel must see
   // the post-motion positions, so feed it mpos as it stands mid-tick
   logic [7:0] mpos [5];
   vopg_view_type view_d;
   always_comb begin
      view_d = view;
      for (int i = 0; i < 5; i++) view_d.pos[i] = mpos[i];
   end

   vopg_pixel u_pixel (
      .view   (view_d),
      .offset (offset),
      .colour (pix_colour),
      .coll   (coll)
   );

   assign offset = VISIBLE_WIDTH - 8'd1 - line_ff;

   always_comb begin
      line_in = line_ff; pf_in = pf_ff; refl_in = refl_ff; edb_in = edb_ff;
      mcnt_in = mcnt_ff; mflg_in = mflg_ff; mctl_in = mctl_ff; sbf_in = sbf_ff;
      for (int i = 0; i < 5; i++) begin pos_in[i] = pos_ff[i]; hm_in[i] = hm_ff[i]; end
      for (int i = 0; i < 8; i++) cx_in[i] = cx_ff[i];
      for (int i = 0; i < 4; i++) colr_in[i] = colr_ff[i];
      for (int i = 0; i < 3; i++) ctrl_in[i] = ctrl_ff[i];
      for (int i = 0; i < 2; i++) begin shp_in[i] = shp_ff[i]; shl_in[i] = shl_ff[i]; end
      for (int i = 0; i < 5; i++) mpos[i] = pos_ff[i];
      st = VS_BLANK; colour = 8'd0; rd = 8'hff;
      cv = mcnt_ff ^ 4'd7;
      extend = sbf_ff[2];
      limit = 8'd0; in_vis = 1'b0;

      if (cmd == CMD_TICK) begin
         // horizontal move, on ticks where the low two line counter bits are zero
         if (line_ff[1:0] == 2'd0) begin
            if (mflg_ff != 5'd0) begin
               for (int c = 0; c < 5; c++) begin
                  if (cv == hm_ff[c]) mflg_in[c] = 1'b0;
                  if (mflg_in[c]) mpos[c] = pos_bump(pos_ff[c]);
               end
            end
            if (mctl_ff[0]) begin
               if (mcnt_ff == 4'd0) mctl_in[0] = 1'b0;
               mcnt_in = mcnt_ff - 4'd1;
            end
         end
         limit = extend ? VISIBLE_WIDTH - 8'd8 : VISIBLE_WIDTH;
         if (sbf_ff[0]) st = (line_ff < SYNC_START) ? VS_SYNC : VS_BLANK;
         else if (line_ff < limit) st = sbf_ff[1] ? VS_BLANK : VS_PIXEL;
         else if (line_ff < SYNC_END) st = VS_BLANK;
         else if (line_ff < SYNC_START) st = VS_SYNC;
         else st = VS_BLANK;
         if (extend && line_ff == VISIBLE_WIDTH - 8'd9) begin
            sbf_in[2] = 1'b0;
            limit = VISIBLE_WIDTH;
         end
         in_vis = line_ff < limit;
         for (int c = 0; c < 5; c++) pos_in[c] = mpos[c];
         if (in_vis) begin
            if (st == VS_PIXEL) begin
               colour = pix_colour;
               for (int i = 0; i < 8; i++) cx_in[i] = cx_ff[i] | coll.col_or[i];
            end
            for (int c = 0; c < 5; c++) pos_in[c] = pos_bump(mpos[c]);
         end
         line_in = (line_ff == 8'd0) ? LINE_LAST : line_ff - 8'd1;
         if (line_in == LINE_LAST) sbf_in[3] = 1'b0;
         if (mctl_in[2:1] != 2'd0) begin
            mctl_in[2:1] = mctl_in[2:1] - 2'd1;
            if (mctl_in[2:1] == 2'd0) begin
               mcnt_in = 4'hf; mflg_in = 5'h1f; mctl_in[0] = 1'b1;
            end
         end
      end else if (cmd == CMD_WRITE) begin
         case (addr)
            A_VSYNC:  sbf_in[0] = wd[1];
            A_VBLANK: sbf_in[1] = wd[1];
            A_WSYNC:  sbf_in[3] = 1'b1;
            A_RSYNC:  line_in = 8'd0;
            A_NUSIZ0: ctrl_in[1] = wd;
            A_NUSIZ1: ctrl_in[2] = wd;
            A_COLUP0: colr_in[0] = wd;
            A_COLUP1: colr_in[1] = wd;
            A_COLUPF: colr_in[2] = wd;
            A_COLUBK: colr_in[3] = wd;
            A_CTRLPF: ctrl_in[0] = wd;
            A_REFP0:  refl_in[0] = wd[3];
            A_REFP1:  refl_in[1] = wd[3];
            A_PF0:    pf_in[3:0] = wd[7:4];
            A_PF1:    for (int i = 0; i < 8; i++) pf_in[4+i] = wd[7-i];
            A_PF2:    pf_in[19:12] = wd;
            A_RESP0:  pos_in[0] = 8'd0;
            A_RESP1:  pos_in[1] = 8'd0;
            A_RESM0:  pos_in[2] = 8'd0;
            A_RESM1:  pos_in[3] = 8'd0;
            A_RESBL:  pos_in[4] = 8'd0;
            A_GRP0: begin
               shl_in[0] = wd;
               if (!edb_ff[5]) shp_in[0] = wd;
               shp_in[1] = shl_ff[1];
            end
            A_GRP1: begin
               edb_in[2] = edb_ff[3];
               shl_in[1] = wd;
               if (!edb_ff[6]) shp_in[1] = wd;
               shp_in[0] = shl_ff[0];
            end
            A_ENAM0:  edb_in[0] = wd[1];
            A_ENAM1:  edb_in[1] = wd[1];
            A_ENABL: begin
               edb_in[3] = wd[1];
               if (!edb_ff[4]) edb_in[2] = wd[1];
            end
            A_HMP0:   hm_in[0] = wd[7:4];
            A_HMP1:   hm_in[1] = wd[7:4];
            A_HMM0:   hm_in[2] = wd[7:4];
            A_HMM1:   hm_in[3] = wd[7:4];
            A_HMBL:   hm_in[4] = wd[7:4];
            A_VDELP0: edb_in[5] = wd[0];
            A_VDELP1: edb_in[6] = wd[0];
            A_VDELBL: edb_in[4] = wd[0];
            A_RESMP0: begin
               if (!wd[1] && edb_ff[7]) pos_in[2] = pos_ff[0];
               edb_in[7] = wd[1];
            end
            A_RESMP1: begin
               if (!wd[1] && edb_ff[8]) pos_in[3] = pos_ff[1];
               edb_in[8] = wd[1];
            end
            A_HMOVE: begin
               sbf_in[2] = 1'b1;
               mctl_in[2:1] = 2'b11;
            end
            A_HMCLR:  for (int i = 0; i < 5; i++) hm_in[i] = 4'd0;
            A_CXCLR: begin
               for (int i = 0; i < 8; i++) cx_in[i] = 8'h3f;
               cx_in[6] = 8'h7f;
            end
            default: ;
         endcase
      end else if (cmd == CMD_READ) begin
         if (!addr[3]) rd = cx_ff[addr[2:0]];
      end
      out_in = {sbf_in[3], rd, (st == VS_PIXEL), colour, st};
   end

   // note: a tick with pixel drawn uses mpos for the view; when no move step
   // happens mpos equals the stored positions
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (take) begin
         vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         vld_ff <= 1'b0;
      end
      if (take) out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= 8'd0; pf_ff <= 20'd0; refl_ff <= 2'd0; edb_ff <= 9'd0;
         mcnt_ff <= 4'd0; mflg_ff <= 5'd0; mctl_ff <= 3'd0; sbf_ff <= 4'd0;
         for (int i = 0; i < 5; i++) begin pos_ff[i] <= 8'd0; hm_ff[i] <= 4'd0; end
         for (int i = 0; i < 8; i++) cx_ff[i] <= 8'hff;
         for (int i = 0; i < 4; i++) colr_ff[i] <= 8'd0;
         for (int i = 0; i < 3; i++) ctrl_ff[i] <= 8'd0;
         for (int i = 0; i < 2; i++) begin shp_ff[i] <= 8'd0; shl_ff[i] <= 8'd0; end
      end else if (take) begin
         line_ff <= line_in; pf_ff <= pf_in; refl_ff <= refl_in; edb_ff <= edb_in;
         mcnt_ff <= mcnt_in; mflg_ff <= mflg_in; mctl_ff <= mctl_in; sbf_ff <= sbf_in;
         for (int i = 0; i < 5; i++) begin pos_ff[i] <= pos_in[i]; hm_ff[i] <= hm_in[i]; end
         for (int i = 0; i < 8; i++) cx_ff[i] <= cx_in[i];
         for (int i = 0; i < 4; i++) colr_ff[i] <= colr_in[i];
         for (int i = 0; i < 3; i++) ctrl_ff[i] <= ctrl_in[i];
         for (int i = 0; i < 2; i++) begin shp_ff[i] <= shp_in[i]; shl_ff[i] <= shl_in[i]; end
      end
   end

   // line counter never leaves its range
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      line_ff <= LINE_LAST) else $error("line counter out of range");

   // a pixel flag goes with the pixel state only
   a_pix_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10] == (rsp_tdata[1:0] == VS_PIXEL)))
      else $error("pixel flag disagrees with state");

   // player 0 position stays inside the visible width
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff[0] < VISIBLE_WIDTH) else $error("player 0 position out of range");

   // a held response word stays until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("response word changed while stalled");

endmodule
